### rtl/core/bdc_pkg.sv
// package for the ballistic drag coefficient block: widths, fixed-point constants,
// the segment table of the eight standard projectile models and the segment test
// no dependencies
package bdc_pkg;

  localparam int MACH_FRAC_BITS = 16;
  localparam int CD_FRAC_BITS   = 16;
  localparam int COEF_FRAC      = 28;
  localparam int MACH_W         = 19;
  localparam int CD_W           = 20;
  localparam int MODEL_W        = 3;
  localparam int NUM_MODELS     = 8;
  localparam int NUM_SEGS       = 6;
  localparam int SEG_IDX_W      = $clog2(NUM_SEGS);
  localparam int COEF_W         = 34;
  // |c1 + m*c2| stays below 118 over the whole mach range, so 37 bits of Q28 hold it
  localparam int INNER_W        = 37;
  localparam int P1_W           = MACH_W + 1 + COEF_W;
  localparam int P2_W           = MACH_W + 1 + INNER_W;
  localparam int ACC_W          = P2_W + 2;
  localparam int CD_SHIFT       = COEF_FRAC - CD_FRAC_BITS;

  localparam longint MILLI    = 1000;
  localparam longint NANO     = 1000000000;
  localparam longint COEF_ONE = longint'(1) << COEF_FRAC;
  localparam longint CD_MAX   = (longint'(1) << (CD_W - 1)) - 1;
  localparam longint CD_MIN   = -(longint'(1) << (CD_W - 1));

  typedef enum logic [MODEL_W-1:0] {
    MODEL_G1 = 3'd0,
    MODEL_G2 = 3'd1,
    MODEL_G5 = 3'd2,
    MODEL_G6 = 3'd3,
    MODEL_G7 = 3'd4,
    MODEL_G8 = 3'd5,
    MODEL_GL = 3'd6,
    MODEL_GI = 3'd7
  } drag_model_e;

  typedef enum logic [1:0] {
    SEG_GT  = 2'd0,
    SEG_GE  = 2'd1,
    SEG_ALL = 2'd2
  } seg_kind_e;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [INNER_W-1:0] inner_t;
  typedef logic signed [P1_W-1:0]    prod1_t;
  typedef logic signed [P2_W-1:0]    prod2_t;

  typedef struct packed {
    seg_kind_e         kind;
    logic [MACH_W:0]   thr;
    coef_t             c0;
    coef_t             c1;
    coef_t             c2;
  } seg_t;

  // segment selection result handed to the evaluator
  typedef struct packed {
    logic [MACH_W-1:0] mach;
    coef_t             c0;
    coef_t             c1;
    coef_t             c2;
  } seg_coef_t;

  // second product and the constant term handed to the final rounding stage
  typedef struct packed {
    prod2_t prod;
    coef_t  c0;
  } horner_out_t;

  // decimal coefficient in units of 1e-9 to Q28, half away from zero
  function automatic longint q28(longint nano);
    longint mag;
    mag = (nano < 0) ? -nano : nano;
    mag = (mag * COEF_ONE + NANO / 2) / NANO;
    return (nano < 0) ? -mag : mag;
  endfunction

  // breakpoint in units of 1e-3; strict uses floor, inclusive uses ceil
  function automatic seg_t mk_seg(seg_kind_e kind, longint bp_milli, longint c0_nano,
                                  longint c1_nano, longint c2_nano);
    seg_t   s;
    longint scaled;
    scaled = bp_milli << MACH_FRAC_BITS;
    s.kind = kind;
    case (kind)
      SEG_GT:  s.thr = (MACH_W + 1)'(scaled / MILLI);
      SEG_GE:  s.thr = (MACH_W + 1)'((scaled + MILLI - 1) / MILLI);
      default: s.thr = '0;
    endcase
    s.c0 = COEF_W'(q28(c0_nano));
    s.c1 = COEF_W'(q28(c1_nano));
    s.c2 = COEF_W'(q28(c2_nano));
    return s;
  endfunction

  function automatic logic seg_hit(seg_t s, logic [MACH_W-1:0] mach);
    logic hit;
    case (s.kind)
      SEG_GT:  hit = {1'b0, mach} > s.thr;
      SEG_GE:  hit = {1'b0, mach} >= s.thr;
      default: hit = 1'b1;
    endcase
    return hit;
  endfunction

  localparam seg_t SEG_PAD = mk_seg(SEG_ALL, 0, 0, 0, 0);

  localparam seg_t SEG_TABLE [NUM_MODELS][NUM_SEGS] = '{
    '{ // G1
      mk_seg(SEG_GT,  2000, 948259000, -248367000, 34434300),
      mk_seg(SEG_GT,  1400, 679681000, 70531100, -57062800),
      mk_seg(SEG_GT,  1100, -1471970000, 64'sd3165290000, -1172820000),
      mk_seg(SEG_GT,   850, -647392000, 942106000, 180604000),
      mk_seg(SEG_GE,   550, 622489000, -1426820000, 1209450000),
      mk_seg(SEG_ALL,    0, 263732000, -165665000, 85221400)},
    '{ // G2
      mk_seg(SEG_GT,  2500, 446561000, -95854800, 7996450),
      mk_seg(SEG_GT,  1200, 701611000, -307510000, 51925600),
      mk_seg(SEG_GT,  1000, -1105010000, 64'sd2771950000, -1266670000),
      mk_seg(SEG_GT,   900, -64'sd2240370000, 64'sd2638670000, 0),
      mk_seg(SEG_GE,   700, 909969000, -1901710000, 1215240000),
      mk_seg(SEG_ALL,    0, 230276000, 210564, -127505000)},
    '{ // G5
      mk_seg(SEG_GT,  2000, 671388000, -185208000, 20450800),
      mk_seg(SEG_GT,  1100, 134374000, 437833000, -157019000),
      mk_seg(SEG_GT,   900, -924258000, 1249040000, 0),
      mk_seg(SEG_GE,   600, 654405000, -1427500000, 998463000),
      mk_seg(SEG_ALL,    0, 186386000, -34213600, -35691000),
      SEG_PAD},
    '{ // G6
      mk_seg(SEG_GT,  2000, 746228000, -255926000, 29172600),
      mk_seg(SEG_GT,  1100, 513638000, -15269000, -33122100),
      mk_seg(SEG_GT,   900, -908802000, 1258140000, 0),
      mk_seg(SEG_GE,   600, 366723000, -458435000, 337906000),
      mk_seg(SEG_ALL,    0, 264481000, -157237000, 117441000),
      SEG_PAD},
    '{ // G7
      mk_seg(SEG_GT,  1900, 439493000, -79354300, 4484770),
      mk_seg(SEG_GT,  1050, 642743000, -272545000, 49247500),
      mk_seg(SEG_GT,   900, -1696550000, 2035570000, 0),
      mk_seg(SEG_GE,   600, 353384000, -692406000, 509469000),
      mk_seg(SEG_ALL,    0, 119775000, -2311180, 2867120),
      SEG_PAD},
    '{ // G8
      mk_seg(SEG_GT,  1100, 639096000, -197471000, 21622100),
      mk_seg(SEG_GE,   925, -64'sd12905300000, 64'sd24918100000, -64'sd11619100000),
      mk_seg(SEG_ALL,    0, 210589000, -1848950, 2111070),
      SEG_PAD, SEG_PAD, SEG_PAD},
    '{ // GL
      mk_seg(SEG_GT,  1000, 286629000, 358893000, -61059800),
      mk_seg(SEG_GE,   800, 1599690000, -64'sd3946550000, 64'sd2831370000),
      mk_seg(SEG_ALL,    0, 333118000, -498448000, 474774000),
      SEG_PAD, SEG_PAD, SEG_PAD},
    '{ // GI
      mk_seg(SEG_GT,  1650, 845362000, -143989000, 11327200),
      mk_seg(SEG_GT,  1200, 630556000, 7013080, 0),
      mk_seg(SEG_GE,   700, 531976000, -1280790000, 1176280000),
      mk_seg(SEG_ALL,    0, 228200000, 0, 0),
      SEG_PAD, SEG_PAD}
  };

endpackage

### rtl/core/bdc_seg_sel.sv
// segment selection stage: breakpoint compares for the selected model and
// coefficient fetch from the constant segment table; depends on bdc_pkg
module bdc_seg_sel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdc_pkg::drag_model_e      drag_model_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bdc_pkg::MACH_W-1:0] mach_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bdc_pkg::seg_coef_t        out_data_o
);
  import bdc_pkg::*;

  logic [SEG_IDX_W-1:0] sel;
  seg_t                 seg;
  logic                 ready;
  logic                 valid_q;
  seg_coef_t            data_d, data_q;

  // first hit in table order wins
  always_comb begin
    sel = SEG_IDX_W'(NUM_SEGS - 1);
    for (int i = NUM_SEGS - 1; i >= 0; i--) begin
      if (seg_hit(SEG_TABLE[drag_model_i][i], mach_i)) begin
        sel = SEG_IDX_W'(i);
      end
    end
  end

  assign seg = SEG_TABLE[drag_model_i][sel];

  always_comb begin
    data_d.mach = mach_i;
    data_d.c0   = seg.c0;
    data_d.c1   = seg.c1;
    data_d.c2   = seg.c2;
  end

  assign ready      = !valid_q || !out_stall_i;
  assign in_stall_o = !ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

### rtl/core/bdc_horner.sv
// three-stage horner evaluator: mach*c2, then c1 + rounded product,
// then mach*inner; depends on bdc_pkg
module bdc_horner (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bdc_pkg::seg_coef_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bdc_pkg::horner_out_t out_data_o
);
  import bdc_pkg::*;

  localparam logic signed [P1_W:0] RND1 = (P1_W + 1)'(longint'(1) << (MACH_FRAC_BITS - 1));

  logic ready1, ready2, ready3;
  logic v1_q, v2_q, v3_q;

  // stage 1
  logic [MACH_W-1:0] mach1_q;
  coef_t             c0_1_q, c1_1_q;
  prod1_t            p1_d, p1_q;
  // stage 2
  logic [MACH_W-1:0] mach2_q;
  coef_t             c0_2_q;
  logic signed [P1_W:0] p1_rnd, p1_sh;
  inner_t            inner_d, inner_q;
  // stage 3
  prod2_t            p2_d, p2_q;
  coef_t             c0_3_q;

  assign ready3     = !v3_q || !out_stall_i;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign p1_d = $signed({1'b0, in_data_i.mach}) * in_data_i.c2;

  // round to nearest, ties up, then drop the mach fraction
  assign p1_rnd  = $signed({p1_q[P1_W-1], p1_q}) + RND1;
  assign p1_sh   = p1_rnd >>> MACH_FRAC_BITS;
  assign inner_d = INNER_W'(p1_sh) + INNER_W'(c1_1_q);

  assign p2_d = $signed({1'b0, mach2_q}) * inner_q;

  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      p1_q    <= p1_d;
      mach1_q <= in_data_i.mach;
      c0_1_q  <= in_data_i.c0;
      c1_1_q  <= in_data_i.c1;
    end
    if (ready2 && v1_q) begin
      inner_q <= inner_d;
      mach2_q <= mach1_q;
      c0_2_q  <= c0_1_q;
    end
    if (ready3 && v2_q) begin
      p2_q   <= p2_d;
      c0_3_q <= c0_2_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign out_data_o.prod = p2_q;
  assign out_data_o.c0   = c0_3_q;

endmodule

### rtl/core/bdc_round_sat.sv
// output stage: adds the constant term, rounds to the cd format and clips
// to the signed cd range with a flag; depends on bdc_pkg
module bdc_round_sat (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bdc_pkg::horner_out_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bdc_pkg::CD_W-1:0]  cd_o,
  output logic                             saturated_o
);
  import bdc_pkg::*;

  localparam logic signed [P2_W:0]  RND2 = (P2_W + 1)'(longint'(1) << (MACH_FRAC_BITS - 1));
  localparam logic signed [ACC_W:0] RND3 = (ACC_W + 1)'(longint'(1) << (CD_SHIFT - 1));
  localparam logic signed [ACC_W:0] CD_HI = (ACC_W + 1)'(CD_MAX);
  localparam logic signed [ACC_W:0] CD_LO = (ACC_W + 1)'(CD_MIN);

  logic signed [P2_W:0]    p2_rnd, p2_sh;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W:0]   cd_rnd, cd_full;
  logic signed [CD_W-1:0]  cd_d, cd_q;
  logic                    sat_d, sat_q;
  logic                    ready;
  logic                    valid_q;

  assign p2_rnd  = $signed({in_data_i.prod[P2_W-1], in_data_i.prod}) + RND2;
  assign p2_sh   = p2_rnd >>> MACH_FRAC_BITS;
  assign acc     = ACC_W'(p2_sh) + ACC_W'(in_data_i.c0);
  assign cd_rnd  = (ACC_W + 1)'(acc) + RND3;
  assign cd_full = cd_rnd >>> CD_SHIFT;

  always_comb begin
    if (cd_full > CD_HI) begin
      cd_d  = CD_W'(CD_MAX);
      sat_d = 1'b1;
    end else if (cd_full < CD_LO) begin
      cd_d  = CD_W'(CD_MIN);
      sat_d = 1'b1;
    end else begin
      cd_d  = CD_W'(cd_full);
      sat_d = 1'b0;
    end
  end

  assign ready      = !valid_q || !out_stall_i;
  assign in_stall_o = !ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      cd_q  <= cd_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = valid_q;
  assign cd_o        = cd_q;
  assign saturated_o = sat_q;

endmodule

### rtl/core/ballistic_drag_coefficient_top.sv
// throughput: one transaction per cycle while the output is not stalled; each stage loads whenever it is empty
//   or its successor moves, so bubbles close up and a stalled output holds
// reset: rst_ni low clears all stage valids and sets drag_model to G1
// stages: segment select, mach*c2, c1 add, mach*inner, c0 add/round/clip
// depends on bdc_pkg, bdc_seg_sel, bdc_horner, bdc_round_sat
module ballistic_drag_coefficient_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             drag_model_we_i,
  input  logic [bdc_pkg::MODEL_W-1:0]      drag_model_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bdc_pkg::MACH_W-1:0]       mach_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bdc_pkg::CD_W-1:0]  cd_o,
  output logic                             saturated_o
);
  import bdc_pkg::*;

  localparam logic signed [CD_W-1:0] CD_HI = CD_W'(CD_MAX);
  localparam logic signed [CD_W-1:0] CD_LO = CD_W'(CD_MIN);

  drag_model_e drag_model_d, drag_model_q;

  logic        sel_valid, sel_stall;
  seg_coef_t   sel_data;
  logic        hor_valid, hor_stall;
  horner_out_t hor_data;

  assign drag_model_d = drag_model_we_i ? drag_model_e'(drag_model_i) : drag_model_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_model_q <= MODEL_G1;
    end else begin
      drag_model_q <= drag_model_d;
    end
  end

  bdc_seg_sel u_seg_sel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .drag_model_i (drag_model_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mach_i       (mach_i),
    .out_valid_o  (sel_valid),
    .out_stall_i  (sel_stall),
    .out_data_o   (sel_data)
  );

  bdc_horner u_horner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sel_valid),
    .in_stall_o  (sel_stall),
    .in_data_i   (sel_data),
    .out_valid_o (hor_valid),
    .out_stall_i (hor_stall),
    .out_data_o  (hor_data)
  );

  bdc_round_sat u_round_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hor_valid),
    .in_stall_o  (hor_stall),
    .in_data_i   (hor_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cd_o        (cd_o),
    .saturated_o (saturated_o)
  );

  // input can only back up when every stage is full and the output is held
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // a clipped result sits exactly on one of the range bounds
  a_sat_on_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (cd_o == CD_HI || cd_o == CD_LO))
    else $error("saturated flag set with cd inside the range");

  // model select changes only through the write port
  a_model_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drag_model_we_i |=> $stable(drag_model_q))
    else $error("drag model changed without a write");

endmodule

### test/bdc_cd_checker.sv
// drag coefficient checker: watches the mach and cd channels of the block,
// predicts each cd and saturation flag on its own and compares in order
// depends on bdc_pkg for port widths and the model and segment enums
module bdc_cd_checker
  import bdc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     drag_model_we_i,
  input  logic [MODEL_W-1:0]       drag_model_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [MACH_W-1:0]        mach_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [CD_W-1:0]   cd_i,
  input  logic                     saturated_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LAW_SEGS  = 6;
  localparam int     MACH_Q    = 16;
  localparam int     CD_Q      = 16;
  localparam int     COEF_Q    = 28;
  localparam longint CD_TOP    = 524287;
  localparam longint CD_BOTTOM = -524288;

  // one segment of a drag law: breakpoint in 1e-3 Mach, coefficients in 1e-9
  typedef struct packed {
    seg_kind_e kind;
    longint    bp_milli;
    longint    c0;
    longint    c1;
    longint    c2;
  } drag_law_t;

  typedef struct packed {
    logic signed [CD_W-1:0] cd;
    logic                   saturated;
    logic [MACH_W-1:0]      mach;
    drag_model_e            model;
  } cd_expect_t;

  localparam drag_law_t LAW_PAD = '{SEG_ALL, 0, 0, 0, 0};

  localparam drag_law_t LAWS [NUM_MODELS][LAW_SEGS] = '{
    '{ // G1
      '{SEG_GT, 2000, 948259000, -248367000, 34434300},
      '{SEG_GT, 1400, 679681000, 70531100, -57062800},
      '{SEG_GT, 1100, -1471970000, 64'sd3165290000, -1172820000},
      '{SEG_GT, 850, -647392000, 942106000, 180604000},
      '{SEG_GE, 550, 622489000, -1426820000, 1209450000},
      '{SEG_ALL, 0, 263732000, -165665000, 85221400}},
    '{ // G2
      '{SEG_GT, 2500, 446561000, -95854800, 7996450},
      '{SEG_GT, 1200, 701611000, -307510000, 51925600},
      '{SEG_GT, 1000, -1105010000, 64'sd2771950000, -1266670000},
      '{SEG_GT, 900, -64'sd2240370000, 64'sd2638670000, 0},
      '{SEG_GE, 700, 909969000, -1901710000, 1215240000},
      '{SEG_ALL, 0, 230276000, 210564, -127505000}},
    '{ // G5
      '{SEG_GT, 2000, 671388000, -185208000, 20450800},
      '{SEG_GT, 1100, 134374000, 437833000, -157019000},
      '{SEG_GT, 900, -924258000, 1249040000, 0},
      '{SEG_GE, 600, 654405000, -1427500000, 998463000},
      '{SEG_ALL, 0, 186386000, -34213600, -35691000},
      LAW_PAD},
    '{ // G6
      '{SEG_GT, 2000, 746228000, -255926000, 29172600},
      '{SEG_GT, 1100, 513638000, -15269000, -33122100},
      '{SEG_GT, 900, -908802000, 1258140000, 0},
      '{SEG_GE, 600, 366723000, -458435000, 337906000},
      '{SEG_ALL, 0, 264481000, -157237000, 117441000},
      LAW_PAD},
    '{ // G7
      '{SEG_GT, 1900, 439493000, -79354300, 4484770},
      '{SEG_GT, 1050, 642743000, -272545000, 49247500},
      '{SEG_GT, 900, -1696550000, 2035570000, 0},
      '{SEG_GE, 600, 353384000, -692406000, 509469000},
      '{SEG_ALL, 0, 119775000, -2311180, 2867120},
      LAW_PAD},
    '{ // G8
      '{SEG_GT, 1100, 639096000, -197471000, 21622100},
      '{SEG_GE, 925, -64'sd12905300000, 64'sd24918100000, -64'sd11619100000},
      '{SEG_ALL, 0, 210589000, -1848950, 2111070},
      LAW_PAD, LAW_PAD, LAW_PAD},
    '{ // GL
      '{SEG_GT, 1000, 286629000, 358893000, -61059800},
      '{SEG_GE, 800, 1599690000, -64'sd3946550000, 64'sd2831370000},
      '{SEG_ALL, 0, 333118000, -498448000, 474774000},
      LAW_PAD, LAW_PAD, LAW_PAD},
    '{ // GI
      '{SEG_GT, 1650, 845362000, -143989000, 11327200},
      '{SEG_GT, 1200, 630556000, 7013080, 0},
      '{SEG_GE, 700, 531976000, -1280790000, 1176280000},
      '{SEG_ALL, 0, 228200000, 0, 0},
      LAW_PAD, LAW_PAD}
  };

  drag_model_e model_q;
  cd_expect_t  cd_expected [$];
  cd_expect_t  head;
  int          step_errors;

  // 1e-9 units to Q28, nearest with ties away from zero
  function automatic longint nano_to_q28(longint nano);
    longint mag;
    mag = (nano < 0) ? -nano : nano;
    mag = (mag * 268435456 + 500000000) / 1000000000;
    return (nano < 0) ? -mag : mag;
  endfunction

  // nearest with ties toward +inf
  function automatic longint round_shift(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic cd_expect_t cd_predict(drag_model_e mdl, logic [MACH_W-1:0] mach);
    cd_expect_t r;
    drag_law_t  law;
    longint     m, scaled, inner, acc, cd_full;
    bit         hit, found;
    m = mach;
    law = LAWS[mdl][LAW_SEGS-1];
    found = 1'b0;
    for (int i = 0; i < LAW_SEGS; i++) begin
      scaled = LAWS[mdl][i].bp_milli * (longint'(1) << MACH_Q);
      // strict compares against the floored breakpoint, inclusive against the ceiling
      case (LAWS[mdl][i].kind)
        SEG_GT:  hit = m > scaled / 1000;
        SEG_GE:  hit = m >= (scaled + 999) / 1000;
        default: hit = 1'b1;
      endcase
      if (hit && !found) begin
        law = LAWS[mdl][i];
        found = 1'b1;
      end
    end
    inner = nano_to_q28(law.c1) + round_shift(m * nano_to_q28(law.c2), MACH_Q);
    acc = nano_to_q28(law.c0) + round_shift(m * inner, MACH_Q);
    cd_full = round_shift(acc, COEF_Q - CD_Q);
    r.mach = mach;
    r.model = mdl;
    r.saturated = 1'b0;
    if (cd_full > CD_TOP) begin
      cd_full = CD_TOP;
      r.saturated = 1'b1;
    end else if (cd_full < CD_BOTTOM) begin
      cd_full = CD_BOTTOM;
      r.saturated = 1'b1;
    end
    r.cd = cd_full[CD_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= MODEL_G1;
      cd_expected.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      step_errors = 0;
      if (in_valid_i && !in_stall_i) begin
        cd_expected.push_back(cd_predict(model_q, mach_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (cd_expected.size() == 0) begin
          $error("cd transaction with nothing expected: cd %0d saturated %0b",
                 cd_i, saturated_i);
          step_errors++;
        end else begin
          head = cd_expected.pop_front();
          if (cd_i !== head.cd) begin
            $error("cd: expected %0d, actual %0d (mach %0d, %s)",
                   head.cd, cd_i, head.mach, head.model.name());
            step_errors++;
          end
          if (saturated_i !== head.saturated) begin
            $error("saturated: expected %0b, actual %0b (mach %0d, %s)",
                   head.saturated, saturated_i, head.mach, head.model.name());
            step_errors++;
          end
        end
      end
      fail_count_o <= fail_count_o + step_errors;
      pending_o <= cd_expected.size();
      if (drag_model_we_i) begin
        model_q <= drag_model_e'(drag_model_i);
      end
    end
  end

endmodule

### test/tb_ballistic_drag_coefficient_top.sv
// testbench top for the ballistic drag coefficient block: clock, reset, model
// selection phases, bursty mach stimulus and an output stall pattern
// depends on bdc_pkg, ballistic_drag_coefficient_top and bdc_cd_checker
module tb_ballistic_drag_coefficient_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bdc_pkg::*;

  localparam int PHASES           = 13;
  localparam int RANDOM_PER_PHASE = 58;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int TAIL_CYCLES      = 20;
  localparam int MACH_MAX         = (1 << MACH_W) - 1;

  localparam drag_model_e PHASE_ORDER [9] = '{
    MODEL_G1, MODEL_GI, MODEL_G1, MODEL_G2, MODEL_G5,
    MODEL_G6, MODEL_G7, MODEL_G8, MODEL_GL
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   drag_model_we_i = 1'b0;
  logic [MODEL_W-1:0]     drag_model_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [MACH_W-1:0]      mach_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic signed [CD_W-1:0] cd_o;
  logic                   saturated_o;

  int          fail_count;
  int          pending_results;
  int unsigned cycle_count = 0;
  int unsigned stall_cycle = 0;

  ballistic_drag_coefficient_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .drag_model_we_i(drag_model_we_i),
    .drag_model_i   (drag_model_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mach_i         (mach_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cd_o           (cd_o),
    .saturated_o    (saturated_o)
  );

  bdc_cd_checker u_cd_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .drag_model_we_i(drag_model_we_i),
    .drag_model_i   (drag_model_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .mach_i         (mach_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cd_i           (cd_o),
    .saturated_i    (saturated_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_results)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver cycles through free-running, random, heavy and light stall stretches
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle / 128) % 4)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 1) == 0);
      2:       out_stall_i <= ((stall_cycle % 4) != 0);
      default: out_stall_i <= ($urandom_range(0, 9) < 2);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // holds the transaction until the block takes it
  task automatic push_mach(input logic [MACH_W-1:0] m);
    in_valid_i <= 1'b1;
    mach_i <= m;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  initial begin
    drag_model_e       cur_model;
    int                burst_left, sel, seg_pick, pick;
    logic [MACH_W-1:0] next_mach;
    burst_left = 0;
    cur_model = MODEL_G1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        cur_model = (phase < 9) ? PHASE_ORDER[phase]
                                : drag_model_e'($urandom_range(0, NUM_MODELS - 1));
        drain_results();
        drag_model_we_i <= 1'b1;
        drag_model_i <= cur_model;
        @(posedge clk_i);
        drag_model_we_i <= 1'b0;
        @(posedge clk_i);
      end
      // ends of the mach range under this model
      push_mach('0);
      push_mach(MACH_MAX[MACH_W-1:0]);

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk_i);
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 20);
        end
        burst_left--;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          next_mach = MACH_W'($urandom_range(0, MACH_MAX));
        end else if (sel < 80) begin
          // land on or next to a segment breakpoint of the selected model
          seg_pick = $urandom_range(0, NUM_SEGS - 1);
          pick = int'(SEG_TABLE[cur_model][seg_pick].thr) + int'($urandom_range(0, 4)) - 2;
          if (pick < 0) pick = 0;
          if (pick > MACH_MAX) pick = MACH_MAX;
          next_mach = pick[MACH_W-1:0];
        end else begin
          next_mach = MACH_W'($urandom_range(0, 3 << MACH_FRAC_BITS));
        end
        push_mach(next_mach);
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
